// File: design/usb_root_hub_port_status_macros.svh
// Assertion macros for the root hub port status block.
// Used by usb_root_hub_port_status; depends on nothing else.
`ifndef USB_ROOT_HUB_PORT_STATUS_MACROS_SVH
`define USB_ROOT_HUB_PORT_STATUS_MACROS_SVH

// check b in the same cycle as a
`define RHPS_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rhps check failed");

// check b in the cycle after a
`define RHPS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rhps check failed");

// delayed check: b must hold some time after a
`define RHPS_ASSERT_TWO(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##2 (b)) \
        else $error("rhps check failed");

`endif

// File: design/usb_rhps_pkg.sv
// Package for the root hub port status block: request codes, feature
// selectors, status bits and result codes. Depends on nothing.
package usb_rhps_pkg;

    typedef logic [2:0]  t_op;
    typedef logic [4:0]  t_feat;
    typedef logic [1:0]  t_res;
    typedef logic [31:0] t_word;

    localparam t_op OP_HUB_STATUS  = 3'd0;
    localparam t_op OP_PORT_STATUS = 3'd1;
    localparam t_op OP_SET_FEATURE = 3'd2;
    localparam t_op OP_CLR_FEATURE = 3'd3;
    localparam t_op OP_ATTACH      = 3'd4;
    localparam t_op OP_DETACH      = 3'd5;
    localparam t_op OP_CHANGE_MAP  = 3'd6;

    localparam t_feat FEAT_RESET    = 5'd4;
    localparam t_feat FEAT_POWER    = 5'd8;
    localparam t_feat FEAT_C_CONN   = 5'd16;
    localparam t_feat FEAT_C_ENABLE = 5'd17;
    localparam t_feat FEAT_C_RESET  = 5'd20;

    localparam t_res RES_DONE   = 2'd0;
    localparam t_res RES_STALL  = 2'd1;
    localparam t_res RES_IGNORE = 2'd2;

    localparam logic [2:0] SPEED_LOW  = 3'd0;
    localparam logic [2:0] SPEED_HIGH = 3'd2;
    localparam logic [2:0] SPEED_MAX  = 3'd3;

    localparam t_word ST_CONNECTION = 32'h0000_0001;
    localparam t_word ST_ENABLE     = 32'h0000_0002;
    localparam t_word ST_RESET      = 32'h0000_0010;
    localparam t_word ST_POWER      = 32'h0000_0100;
    localparam t_word ST_LOW_SPEED  = 32'h0000_0200;
    localparam t_word ST_HIGH_SPEED = 32'h0000_0400;
    localparam t_word CH_CONNECTION = 32'h0001_0000;
    localparam t_word CH_ENABLE     = 32'h0002_0000;
    localparam t_word CH_RESET      = 32'h0010_0000;

endpackage

// File: design/usb_root_hub_port_status.sv
// Root hub port status: status words in a memory with a registered read, change flags in flops.
// Uses usb_rhps_pkg and usb_root_hub_port_status_macros.svh.
// On accept the memory read is registered; the modify/write-back state follows (busy high
// in it), then o_result_valid is registered. No new request is taken while busy.
// Synchronous active-low reset: idle, all ports read as zero, change flags clear.
// Results show for one cycle; the receiver cannot stall them.
`include "usb_root_hub_port_status_macros.svh"

module usb_root_hub_port_status #(
    parameter int NUM_PORTS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_port_number,
    input  logic [4:0]  i_feature,
    input  logic [2:0]  i_device_speed,
    output logic        o_result_valid,
    output logic [1:0]  o_result_status,
    output logic [31:0] o_status_word,
    output logic [15:0] o_change_bitmap,
    output logic [1:0]  o_change_bytes
);

    localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [1:0] MAP_BYTES = 2'((NUM_PORTS + 8) / 8);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_MODIFY = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [31:0]          r_mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] r_vld;
    logic [NUM_PORTS-1:0] r_chg;
    logic [NUM_PORTS-1:0] n_chg;

    usb_rhps_pkg::t_op    r_op;
    usb_rhps_pkg::t_feat  r_feat;
    logic [2:0]           r_speed;
    logic                 r_port_ok;
    logic [IDX_W-1:0]     r_idx;
    logic [31:0]          r_rdata;
    logic                 r_rd_vld;

    logic                 r_out_stb;
    usb_rhps_pkg::t_res   r_res;
    logic [31:0]          r_word;
    logic [15:0]          r_bm;
    logic [1:0]           r_nb;

    usb_rhps_pkg::t_res   n_res;
    logic [31:0]          n_out_word;
    logic [15:0]          n_bm;
    logic [1:0]           n_nb;
    logic [31:0]          n_word;
    logic                 n_wr;

    logic                 accept;
    logic                 in_port_ok;
    logic [7:0]           in_port_m1;
    logic [IDX_W-1:0]     in_idx;
    logic [31:0]          cur_word;

    assign busy       = (r_state == S_MODIFY);
    assign accept     = start && !busy;
    assign in_port_ok = (i_port_number != 8'd0) && (i_port_number <= 8'(NUM_PORTS));
    assign in_port_m1 = i_port_number - 8'd1;
    assign in_idx     = in_port_ok ? in_port_m1[IDX_W-1:0] : '0;
    assign cur_word   = r_rd_vld ? r_rdata : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_MODIFY;
            S_MODIFY: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_res      = usb_rhps_pkg::RES_DONE;
        n_out_word = '0;
        n_bm       = '0;
        n_nb       = '0;
        n_word     = cur_word;
        n_wr       = 1'b0;
        n_chg      = r_chg;
        case (r_op)
            usb_rhps_pkg::OP_HUB_STATUS: begin
                n_res = usb_rhps_pkg::RES_DONE;
            end
            usb_rhps_pkg::OP_PORT_STATUS: begin
                if (!r_port_ok) n_res = usb_rhps_pkg::RES_STALL;
                else n_out_word = cur_word;
            end
            usb_rhps_pkg::OP_SET_FEATURE: begin
                if (!r_port_ok) begin
                    n_res = usb_rhps_pkg::RES_STALL;
                end else if (r_feat == usb_rhps_pkg::FEAT_POWER) begin
                    n_word = cur_word | usb_rhps_pkg::ST_POWER;
                    n_wr   = 1'b1;
                end else if (r_feat == usb_rhps_pkg::FEAT_RESET) begin
                    n_word = (cur_word & ~usb_rhps_pkg::ST_RESET)
                           | usb_rhps_pkg::ST_ENABLE | usb_rhps_pkg::CH_RESET;
                    n_wr   = 1'b1;
                    n_chg[r_idx] = 1'b1;
                end
            end
            usb_rhps_pkg::OP_CLR_FEATURE: begin
                if (!r_port_ok) begin
                    n_res = usb_rhps_pkg::RES_STALL;
                end else if (r_feat == usb_rhps_pkg::FEAT_C_CONN) begin
                    n_word = cur_word & ~usb_rhps_pkg::CH_CONNECTION;
                    n_wr   = 1'b1;
                end else if (r_feat == usb_rhps_pkg::FEAT_C_RESET) begin
                    n_word = cur_word & ~usb_rhps_pkg::CH_RESET;
                    n_wr   = 1'b1;
                end else if (r_feat == usb_rhps_pkg::FEAT_C_ENABLE) begin
                    n_word = cur_word & ~usb_rhps_pkg::CH_ENABLE;
                    n_wr   = 1'b1;
                end
            end
            usb_rhps_pkg::OP_ATTACH: begin
                if (!r_port_ok || (r_speed > usb_rhps_pkg::SPEED_MAX)) begin
                    n_res = usb_rhps_pkg::RES_IGNORE;
                end else begin
                    n_word = usb_rhps_pkg::ST_CONNECTION | usb_rhps_pkg::ST_POWER
                           | usb_rhps_pkg::CH_CONNECTION;
                    if (r_speed == usb_rhps_pkg::SPEED_LOW)
                        n_word = n_word | usb_rhps_pkg::ST_LOW_SPEED;
                    else if (r_speed == usb_rhps_pkg::SPEED_HIGH)
                        n_word = n_word | usb_rhps_pkg::ST_HIGH_SPEED;
                    n_wr   = 1'b1;
                    n_chg[r_idx] = 1'b1;
                end
            end
            usb_rhps_pkg::OP_DETACH: begin
                if (!r_port_ok) begin
                    n_res = usb_rhps_pkg::RES_IGNORE;
                end else begin
                    n_word = usb_rhps_pkg::ST_POWER | usb_rhps_pkg::CH_CONNECTION;
                    n_wr   = 1'b1;
                    n_chg[r_idx] = 1'b1;
                end
            end
            usb_rhps_pkg::OP_CHANGE_MAP: begin
                n_bm  = 16'({r_chg, 1'b0});
                n_nb  = (r_chg != '0) ? MAP_BYTES : 2'd0;
                n_chg = '0;
            end
            default: begin
                n_res = usb_rhps_pkg::RES_STALL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_chg     <= '0;
            r_out_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_stb <= busy;
            if (busy) begin
                r_chg <= n_chg;
                if (n_wr) r_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_operation;
            r_feat    <= i_feature;
            r_speed   <= i_device_speed;
            r_port_ok <= in_port_ok;
            r_idx     <= in_idx;
            r_rdata   <= r_mem[in_idx];
            r_rd_vld  <= r_vld[in_idx];
        end
        if (busy && n_wr) begin
            r_mem[r_idx] <= n_word;
        end
        if (busy) begin
            r_res  <= n_res;
            r_word <= n_out_word;
            r_bm   <= n_bm;
            r_nb   <= n_nb;
        end
    end

    assign o_result_valid  = r_out_stb;
    assign o_result_status = r_res;
    assign o_status_word   = r_word;
    assign o_change_bitmap = r_bm;
    assign o_change_bytes  = r_nb;

    `RHPS_ASSERT_TWO(a_accept_gives_result, i_clk, i_rst_n, start && !busy, o_result_valid)
    `RHPS_ASSERT_NEXT(a_busy_one_cycle, i_clk, i_rst_n, busy, !busy)
    `RHPS_ASSERT_NOW(a_bytes_need_bits, i_clk, i_rst_n, o_result_valid && (o_change_bytes != 2'd0), o_change_bitmap != 16'd0)
    `RHPS_ASSERT_NEXT(a_map_clears_flags, i_clk, i_rst_n, busy && (r_op == usb_rhps_pkg::OP_CHANGE_MAP), r_chg == '0)

endmodule
